FILE: rtl/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants for the suffix array seed match core
// Store sizes, opcode and register codes, and the search state machine type.
// ----------------------------------------------------------------------------
package ssm_pkg;

	// Default store sizes
	localparam int TEXT_SIZE_DEF   = 65536;
	localparam int INDEX_SIZE_DEF  = 65536;
	localparam int BUCKET_SIZE_DEF = 4096;
	localparam int QUERY_SIZE_DEF  = 64;
	localparam int MAX_LEVELS_DEF  = 8;

	// Search depth cap and result count cap
	localparam int DEPTH_CAP = 64;

	// Item opcodes
	typedef enum logic [2:0] {
		OP_LOAD_TEXT   = 3'd0,
		OP_LOAD_SUFFIX = 3'd1,
		OP_LOAD_BUCKET = 3'd2,
		OP_LOAD_QUERY  = 3'd3,
		OP_MATCH       = 3'd4,
		OP_COUNT       = 3'd5
	} opcode_t;

	// Register indexes (8-byte stride)
	localparam logic [2:0] REG_ALPH_SIZE     = 3'd0;
	localparam logic [2:0] REG_BUCKET_LEVELS = 3'd1;
	localparam logic [2:0] REG_SEED_WEIGHT   = 3'd2;
	localparam logic [2:0] REG_SEED_OFFSETS  = 3'd3;
	localparam logic [2:0] REG_MAX_HITS      = 3'd4;
	localparam logic [2:0] REG_MIN_DEPTH     = 3'd5;
	localparam logic [2:0] REG_INDEX_COUNT   = 3'd6;

	// Search sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_QSYM,
		ST_BMUL,
		ST_BRD0,
		ST_BRD1,
		ST_BRD2,
		ST_PROBE,
		ST_SUF,
		ST_TXT,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/ssm_ram.sv
// ----------------------------------------------------------------------------
// ssm_ram: single-port synchronous RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module ssm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	assign rdata = rd_q;

endmodule

FILE: rtl/suffix_array_seed_match_core.sv
// ----------------------------------------------------------------------------
// suffix_array_seed_match_core: bucketed binary search over a suffix array
// Four stores (text, suffix positions, bucket table, query) filled by load
// items; match and count items narrow a suffix range under a spaced seed.
// ----------------------------------------------------------------------------
// Load items are written straight into their store.
// A match or count item first builds the level step table, then for each
// bucket level reads the query symbol, does the step multiply and makes two
// bucket reads on the single bucket port, then for each seed depth runs two
// equal-range binary searches, each probe being a suffix read, a text read
// and a compare. The single-port text and suffix memories set the probe
// cost.
// No clearing pass is needed after reset. While a search runs, in_ready is
// low; a count item's results leave one behind the search so the final one
// can carry last.
// ----------------------------------------------------------------------------
module suffix_array_seed_match_core #(
	parameter int TEXT_SIZE   = ssm_pkg::TEXT_SIZE_DEF,
	parameter int INDEX_SIZE  = ssm_pkg::INDEX_SIZE_DEF,
	parameter int BUCKET_SIZE = ssm_pkg::BUCKET_SIZE_DEF,
	parameter int QUERY_SIZE  = ssm_pkg::QUERY_SIZE_DEF,
	parameter int MAX_LEVELS  = ssm_pkg::MAX_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] address,
	input  logic [16:0] data,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [16:0] range_begin,
	output logic [16:0] range_end,
	output logic [6:0]  match_depth,
	output logic [16:0] hit_count,
	output logic        last,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int TAW = $clog2(TEXT_SIZE);
	localparam int IAW = $clog2(INDEX_SIZE);
	localparam int BAW = $clog2(BUCKET_SIZE);
	localparam int QAW = $clog2(QUERY_SIZE);
	localparam int SW  = BAW + 1;              // step / bucket pointer, saturates
	localparam int PW  = SW + 9;               // product width
	localparam int LW  = $clog2(MAX_LEVELS + 1);
	localparam int NLV = MAX_LEVELS + 1;

	// Configuration registers
	logic [7:0]  alph_q;
	logic [3:0]  levels_q;
	logic [3:0]  weight_q;
	logic [63:0] offsets_q;
	logic [16:0] max_hits_q;
	logic [6:0]  min_depth_q;
	logic [16:0] idx_cnt_q;

	// Control state
	ssm_pkg::state_t state_q, state_d;
	logic        count_q;
	logic        pass2_q;
	logic        pend_v_q;
	logic        ovalid_q;
	logic [6:0]  nres_q;

	// Search payload
	logic [SW-1:0] steps_q [NLV];
	logic [SW-1:0] step_q;
	logic [SW-1:0] st_q;
	logic [SW-1:0] bptr_q;
	logic [LW-1:0] j_q;
	logic [2:0]    phase_q;
	logic [14:0]   shift_q;
	logic [14:0]   qpos_q;
	logic [16:0]   beg_q, end_q, lo_q, hi_q, mid_q;
	logic [6:0]    depth_q;
	logic [6:0]    mind_q;
	logic [7:0]    sym_q;
	logic          qin_q, bin_q, tin_q;
	logic [16:0]   pbeg_q, pend_q;
	logic [6:0]    pdep_q;
	logic [16:0]   obeg_q, oend_q;
	logic [6:0]    odep_q;
	logic          olast_q;

	// Memory ports
	logic            t_we, s_we, b_we, q_we;
	logic [TAW-1:0]  t_addr;
	logic [IAW-1:0]  s_addr;
	logic [BAW-1:0]  b_addr;
	logic [QAW-1:0]  q_addr;
	logic [7:0]      t_rdata, q_rdata;
	logic [15:0]     s_rdata;
	logic [16:0]     b_rdata;

	// ---------------------------------------------------------------- config
	logic cfg_wr;
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alph_q      <= 8'd4;
			levels_q    <= 4'd0;
			weight_q    <= 4'd1;
			offsets_q   <= 64'h0101_0101_0101_0101;
			max_hits_q  <= 17'd65536;
			min_depth_q <= 7'd0;
			idx_cnt_q   <= 17'd0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				ssm_pkg::REG_ALPH_SIZE:     alph_q      <= pwdata[7:0];
				ssm_pkg::REG_BUCKET_LEVELS: levels_q    <= pwdata[3:0];
				ssm_pkg::REG_SEED_WEIGHT:   weight_q    <= pwdata[3:0];
				ssm_pkg::REG_SEED_OFFSETS:  offsets_q   <= pwdata;
				ssm_pkg::REG_MAX_HITS:      max_hits_q  <= pwdata[16:0];
				ssm_pkg::REG_MIN_DEPTH:     min_depth_q <= pwdata[6:0];
				ssm_pkg::REG_INDEX_COUNT:   idx_cnt_q   <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			ssm_pkg::REG_ALPH_SIZE:     prdata = 64'(alph_q);
			ssm_pkg::REG_BUCKET_LEVELS: prdata = 64'(levels_q);
			ssm_pkg::REG_SEED_WEIGHT:   prdata = 64'(weight_q);
			ssm_pkg::REG_SEED_OFFSETS:  prdata = offsets_q;
			ssm_pkg::REG_MAX_HITS:      prdata = 64'(max_hits_q);
			ssm_pkg::REG_MIN_DEPTH:     prdata = 64'(min_depth_q);
			ssm_pkg::REG_INDEX_COUNT:   prdata = 64'(idx_cnt_q);
			default:                    prdata = 64'd0;
		endcase
	end

	// ------------------------------------------------------- effective values
	logic [4:0]  lv;
	logic [3:0]  weff;
	logic [16:0] cnt;
	logic [2:0]  phase_nxt;
	logic [7:0]  off;

	assign lv   = (5'(levels_q) > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : 5'(levels_q);
	assign weff = (weight_q == 4'd0) ? 4'd1 : ((weight_q > 4'd8) ? 4'd8 : weight_q);
	assign cnt  = (32'(idx_cnt_q) > 32'(INDEX_SIZE)) ? 17'(INDEX_SIZE) : idx_cnt_q;
	assign phase_nxt = ((4'(phase_q) + 4'd1) == weff) ? 3'd0 : phase_q + 3'd1;
	assign off  = offsets_q[{phase_q, 3'b000} +: 8];

	// ------------------------------------------------------- datapath helpers
	logic        acc;
	logic        in_bucket;
	logic        few;
	logic        chk_stop, chk_emit, out_free, emit_stall;
	logic [7:0]  sym;
	logic        letter;
	logic [PW-1:0] step_wide, bsum;
	logic [SW-1:0] step_new, bptr_new;
	logic [SW:0]   bend;
	logic [16:0] bval;
	logic [16:0] mid;
	logic [31:0] tsum;
	logic [7:0]  tsym;
	logic        go_lo;

	assign in_ready  = (state_q == ssm_pkg::ST_IDLE);
	assign acc       = in_valid & in_ready;
	assign in_bucket = (7'(lv) > depth_q);
	assign few       = ((end_q - beg_q) <= max_hits_q) && (depth_q >= mind_q);
	assign out_free  = !ovalid_q || out_ready;

	// Loop head decision
	always_comb begin
		if (count_q) begin
			chk_stop = (beg_q == end_q) ||
				(!in_bucket && (nres_q >= 7'(ssm_pkg::DEPTH_CAP)));
			chk_emit = !chk_stop;
		end else begin
			chk_stop = few || (!in_bucket && (depth_q >= 7'(ssm_pkg::DEPTH_CAP)));
			chk_emit = 1'b0;
		end
	end
	assign emit_stall = chk_emit && pend_v_q && !out_free;

	assign sym    = qin_q ? q_rdata : 8'hFF;
	assign letter = sym < alph_q;

	// Level step: step*alph+1, saturated at the bucket size
	assign step_wide = PW'(step_q) * PW'(alph_q) + PW'(1);
	assign step_new  = (step_wide >= PW'(BUCKET_SIZE)) ? SW'(BUCKET_SIZE) : step_wide[SW-1:0];

	// Bucket pointer advance, saturated
	assign bsum     = PW'(bptr_q) + PW'(sym_q) * PW'(st_q);
	assign bptr_new = (bsum >= PW'(BUCKET_SIZE)) ? SW'(BUCKET_SIZE) : bsum[SW-1:0];
	assign bend     = (SW+1)'(bptr_q) + (SW+1)'(st_q);
	assign bval     = bin_q ? ((b_rdata > cnt) ? cnt : b_rdata) : cnt;

	// Binary search probe
	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign tsum  = 32'(s_rdata) + 32'(shift_q);
	assign tsym  = tin_q ? t_rdata : 8'hFF;
	assign go_lo = pass2_q ? (tsym <= sym_q) : (tsym < sym_q);

	// ----------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssm_pkg::ST_IDLE:
				if (acc && (opcode == ssm_pkg::OP_MATCH || opcode == ssm_pkg::OP_COUNT))
					state_d = ssm_pkg::ST_PREP;
			ssm_pkg::ST_PREP:
				if (5'(j_q) == lv) state_d = ssm_pkg::ST_CHECK;
			ssm_pkg::ST_CHECK:
				if (chk_stop) state_d = ssm_pkg::ST_DONE;
				else if (!emit_stall) state_d = ssm_pkg::ST_QSYM;
			ssm_pkg::ST_QSYM:
				if (letter) state_d = in_bucket ? ssm_pkg::ST_BMUL : ssm_pkg::ST_PROBE;
				else state_d = count_q ? ssm_pkg::ST_DONE : ssm_pkg::ST_CHECK;
			ssm_pkg::ST_BMUL:  state_d = ssm_pkg::ST_BRD0;
			ssm_pkg::ST_BRD0:  state_d = ssm_pkg::ST_BRD1;
			ssm_pkg::ST_BRD1:  state_d = ssm_pkg::ST_BRD2;
			ssm_pkg::ST_BRD2:  state_d = ssm_pkg::ST_CHECK;
			ssm_pkg::ST_PROBE:
				if (lo_q < hi_q) state_d = ssm_pkg::ST_SUF;
				else if (pass2_q) state_d = ssm_pkg::ST_CHECK;
			ssm_pkg::ST_SUF:   state_d = ssm_pkg::ST_TXT;
			ssm_pkg::ST_TXT:   state_d = ssm_pkg::ST_PROBE;
			ssm_pkg::ST_DONE:
				if (out_free) state_d = ssm_pkg::ST_IDLE;
			default: state_d = ssm_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------- memory controls
	always_comb begin
		t_we   = 1'b0;
		s_we   = 1'b0;
		b_we   = 1'b0;
		q_we   = 1'b0;
		t_addr = TAW'(address);
		s_addr = IAW'(address);
		b_addr = BAW'(address);
		q_addr = QAW'(address);
		case (state_q)
			ssm_pkg::ST_IDLE: begin
				if (acc) begin
					t_we = (opcode == ssm_pkg::OP_LOAD_TEXT) &&
						(32'(address) < 32'(TEXT_SIZE));
					s_we = (opcode == ssm_pkg::OP_LOAD_SUFFIX) &&
						(32'(address) < 32'(INDEX_SIZE));
					b_we = (opcode == ssm_pkg::OP_LOAD_BUCKET) &&
						(32'(address) < 32'(BUCKET_SIZE));
					q_we = (opcode == ssm_pkg::OP_LOAD_QUERY) &&
						(32'(address) < 32'(QUERY_SIZE));
				end
			end
			ssm_pkg::ST_CHECK: q_addr = qpos_q[QAW-1:0];
			ssm_pkg::ST_BRD0:  b_addr = bptr_q[BAW-1:0];
			ssm_pkg::ST_BRD1:  b_addr = bend[BAW-1:0];
			ssm_pkg::ST_PROBE: s_addr = mid[IAW-1:0];
			ssm_pkg::ST_SUF:   t_addr = tsum[TAW-1:0];
			default: ;
		endcase
	end

	// -------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ssm_pkg::ST_IDLE;
			count_q  <= 1'b0;
			pass2_q  <= 1'b0;
			pend_v_q <= 1'b0;
			ovalid_q <= 1'b0;
			nres_q   <= 7'd0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				ssm_pkg::ST_IDLE: begin
					count_q  <= (opcode == ssm_pkg::OP_COUNT);
					pend_v_q <= 1'b0;
					nres_q   <= 7'd0;
				end
				ssm_pkg::ST_CHECK: begin
					if (!chk_stop && chk_emit && !emit_stall) begin
						if (pend_v_q) ovalid_q <= 1'b1;
						pend_v_q <= 1'b1;
						nres_q   <= nres_q + 7'd1;
					end
				end
				ssm_pkg::ST_QSYM: pass2_q <= 1'b0;
				ssm_pkg::ST_PROBE:
					if (!(lo_q < hi_q)) pass2_q <= 1'b1;
				ssm_pkg::ST_DONE:
					if (out_free) begin
						ovalid_q <= 1'b1;
						pend_v_q <= 1'b0;
					end
				default: ;
			endcase
		end
	end

	// -------------------------------------------------------- payload regs
	always_ff @(posedge clk) begin
		case (state_q)
			ssm_pkg::ST_IDLE: begin
				j_q     <= '0;
				step_q  <= '0;
				shift_q <= '0;
				phase_q <= '0;
				bptr_q  <= '0;
				beg_q   <= '0;
				end_q   <= cnt;
				depth_q <= '0;
				qpos_q  <= '0;
				mind_q  <= min_depth_q;
			end
			// Build level steps from the deepest level up, and the text shift
			ssm_pkg::ST_PREP: begin
				steps_q[LW'(lv - 5'(j_q))] <= step_new;
				step_q <= step_new;
				j_q    <= j_q + LW'(1);
				if (5'(j_q) < lv) begin
					shift_q <= shift_q + 15'(off);
					phase_q <= phase_nxt;
				end else begin
					phase_q <= '0;
				end
			end
			ssm_pkg::ST_CHECK: begin
				qin_q <= (32'(qpos_q) < 32'(QUERY_SIZE));
				if (!chk_stop && chk_emit && !emit_stall) begin
					if (pend_v_q) begin
						obeg_q  <= pbeg_q;
						oend_q  <= pend_q;
						odep_q  <= pdep_q;
						olast_q <= 1'b0;
					end
					pbeg_q <= beg_q;
					pend_q <= end_q;
					pdep_q <= depth_q;
				end
			end
			ssm_pkg::ST_QSYM: begin
				sym_q <= sym;
				lo_q  <= beg_q;
				hi_q  <= end_q;
				if (letter && in_bucket) begin
					qpos_q  <= qpos_q + 15'(off);
					depth_q <= depth_q + 7'd1;
					phase_q <= phase_nxt;
					st_q    <= steps_q[LW'(depth_q + 7'd1)];
				end else if (!letter && !count_q) begin
					beg_q  <= end_q;
					mind_q <= '0;
				end
			end
			ssm_pkg::ST_BMUL: bptr_q <= bptr_new;
			ssm_pkg::ST_BRD0: bin_q <= (32'(bptr_q) < 32'(BUCKET_SIZE));
			ssm_pkg::ST_BRD1: begin
				beg_q <= bval;
				bin_q <= (32'(bend) < 32'(BUCKET_SIZE));
			end
			ssm_pkg::ST_BRD2: begin
				end_q <= bval;
				if (beg_q > bval) beg_q <= bval;
			end
			ssm_pkg::ST_PROBE: begin
				mid_q <= mid;
				if (!(lo_q < hi_q)) begin
					if (!pass2_q) begin
						beg_q <= lo_q;
						hi_q  <= end_q;
					end else begin
						end_q   <= lo_q;
						qpos_q  <= qpos_q + 15'(off);
						shift_q <= shift_q + 15'(off);
						depth_q <= depth_q + 7'd1;
						phase_q <= phase_nxt;
					end
				end
			end
			ssm_pkg::ST_SUF: tin_q <= (tsum < 32'(TEXT_SIZE));
			ssm_pkg::ST_TXT:
				if (go_lo) lo_q <= mid_q + 17'd1;
				else hi_q <= mid_q;
			ssm_pkg::ST_DONE:
				if (out_free) begin
					olast_q <= 1'b1;
					if (count_q && pend_v_q) begin
						obeg_q <= pbeg_q;
						oend_q <= pend_q;
						odep_q <= pdep_q;
					end else begin
						obeg_q <= beg_q;
						oend_q <= end_q;
						odep_q <= depth_q;
					end
				end
			default: ;
		endcase
	end

	// ------------------------------------------------------------- outputs
	assign out_valid   = ovalid_q;
	assign range_begin = obeg_q;
	assign range_end   = oend_q;
	assign match_depth = odep_q;
	assign hit_count   = oend_q - obeg_q;
	assign last        = olast_q;

	// ------------------------------------------------------------ memories
	ssm_ram #(.WIDTH(8), .DEPTH(TEXT_SIZE)) u_text (
		.clk(clk), .we(t_we), .addr(t_addr), .wdata(data[7:0]), .rdata(t_rdata)
	);

	ssm_ram #(.WIDTH(16), .DEPTH(INDEX_SIZE)) u_suffix (
		.clk(clk), .we(s_we), .addr(s_addr), .wdata(data[15:0]), .rdata(s_rdata)
	);

	ssm_ram #(.WIDTH(17), .DEPTH(BUCKET_SIZE)) u_bucket (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(data), .rdata(b_rdata)
	);

	ssm_ram #(.WIDTH(8), .DEPTH(QUERY_SIZE)) u_query (
		.clk(clk), .we(q_we), .addr(q_addr), .wdata(data[7:0]), .rdata(q_rdata)
	);

	// ----------------------------------------------------------- assertions
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> range_begin <= range_end)
		else $error("result range begins past its end");

	a_check_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssm_pkg::ST_CHECK |-> beg_q <= end_q)
		else $error("search range crossed at loop head");

	a_depth_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_depth <= 7'(ssm_pkg::DEPTH_CAP))
		else $error("result depth beyond cap");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssm_pkg::ST_DONE && !out_free |=> state_q == ssm_pkg::ST_DONE)
		else $error("search finished without a free result slot");

endmodule
